/* rtl/akt_pkg.sv */
package akt_pkg;

	localparam int KEY_W = 64;
	localparam int CNT_W = 7;
	localparam int REQ_W = 2;
	localparam int STS_W = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_LOOKUP = 2'd1,
		REQ_READ   = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_t;

	localparam logic [STS_W-1:0] STS_OK        = 2'd0;
	localparam logic [STS_W-1:0] STS_FULL      = 2'd1;
	localparam logic [STS_W-1:0] STS_BAD_ENTRY = 2'd2;

	// result kinds the controller asks the datapath to post
	typedef enum logic [2:0] {
		RES_OK,
		RES_FULL,
		RES_BAD,
		RES_HIT,
		RES_KEY
	} res_sel_t;

	typedef struct packed {
		logic     latch;
		logic     do_insert;
		logic     do_clear;
		logic     scan_first;
		logic     scan_next;
		logic     read_issue;
		logic     finish;
		res_sel_t res_sel;
	} akt_cmd_t;

	typedef struct packed {
		req_t req;
		logic full;
		logic bad_entry;
		logic empty;
		logic match;
		logic last;
	} akt_stat_t;

endpackage

/* rtl/access_key_table.sv */
// Access key table: stores up to MAX_KEYS 64-bit keys and serves one request
// word at a time.
// Request channel: a word (req_type, key_value, entry_number) is taken at a
// clock edge where start is high and busy is low. busy stays high until the
// result is posted.
// Result channel: done is high for exactly one cycle; status, found, key_out
// and count_now are valid in that cycle. The receiver cannot stall, so the
// result must be captured then.
// Insert, clear, a failed read and a lookup on an empty table finish in the
// execute state; a good read passes through a registered memory read in the
// read wait state; a lookup compares k stored entries, k at most count. The
// scan compares one stored entry per cycle through the single read port of
// the key memory, so a full-table miss compares every stored entry.
// A new word may be accepted in the cycle done is high.
// Reset (arst_n low) empties the table and returns to idle; the key memory
// is not cleared, since only entries below the count can be read.
module access_key_table import akt_pkg::*; #(
	parameter int MAX_KEYS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [REQ_W-1:0] req_type,
	input  logic [KEY_W-1:0] key_value,
	input  logic [CNT_W-1:0] entry_number,
	output logic             done,
	output logic [STS_W-1:0] status,
	output logic             found,
	output logic [KEY_W-1:0] key_out,
	output logic [CNT_W-1:0] count_now
);

	akt_cmd_t  cmd;
	akt_stat_t stat;

	akt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	akt_dpath #(
		.MAX_KEYS (MAX_KEYS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.req_type     (req_type),
		.key_value    (key_value),
		.entry_number (entry_number),
		.status       (status),
		.found        (found),
		.key_out      (key_out),
		.count_now    (count_now)
	);

endmodule

/* rtl/akt_dpath.sv */
module akt_dpath import akt_pkg::*; #(
	parameter int MAX_KEYS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  akt_cmd_t         cmd,
	output akt_stat_t        stat,
	input  logic [REQ_W-1:0] req_type,
	input  logic [KEY_W-1:0] key_value,
	input  logic [CNT_W-1:0] entry_number,
	output logic [STS_W-1:0] status,
	output logic             found,
	output logic [KEY_W-1:0] key_out,
	output logic [CNT_W-1:0] count_now
);

	localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

	logic [KEY_W-1:0] mem [MAX_KEYS];

	req_t             req_q;
	logic [KEY_W-1:0] key_q;
	logic [CNT_W-1:0] entry_q;
	logic [CNT_W-1:0] count_q;
	logic [IW-1:0]    idx_q;
	logic [KEY_W-1:0] rd_data_q;
	logic [STS_W-1:0] status_q;
	logic             found_q;
	logic [KEY_W-1:0] key_out_q;

	logic [CNT_W-1:0] entry_m1;
	logic [CNT_W-1:0] count_m1;
	logic [IW-1:0]    rd_addr;
	logic             rd_en;

	assign entry_m1 = entry_q - CNT_W'(1);
	assign count_m1 = count_q - CNT_W'(1);

	always_comb begin
		rd_addr = '0;
		if (cmd.read_issue) begin
			rd_addr = entry_m1[IW-1:0];
		end else if (cmd.scan_next) begin
			rd_addr = idx_q + IW'(1);
		end
	end

	assign rd_en = cmd.scan_first | cmd.scan_next | cmd.read_issue;

	assign stat.req       = req_q;
	assign stat.full      = (count_q >= CNT_W'(MAX_KEYS));
	assign stat.bad_entry = (entry_q == '0) || (entry_q > count_q);
	assign stat.empty     = (count_q == '0);
	assign stat.match     = (rd_data_q == key_q);
	assign stat.last      = (CNT_W'(idx_q) == count_m1);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q   <= req_t'(req_type);
			key_q   <= key_value;
			entry_q <= entry_number;
		end
		if (cmd.do_insert) begin
			mem[count_q[IW-1:0]] <= key_q;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (cmd.scan_first) begin
			idx_q <= '0;
		end else if (cmd.scan_next) begin
			idx_q <= rd_addr;
		end
		if (cmd.finish) begin
			case (cmd.res_sel)
				RES_FULL: begin
					status_q  <= STS_FULL;
					found_q   <= 1'b0;
					key_out_q <= '0;
				end
				RES_BAD: begin
					status_q  <= STS_BAD_ENTRY;
					found_q   <= 1'b0;
					key_out_q <= '0;
				end
				RES_HIT: begin
					status_q  <= STS_OK;
					found_q   <= 1'b1;
					key_out_q <= '0;
				end
				RES_KEY: begin
					status_q  <= STS_OK;
					found_q   <= 1'b0;
					key_out_q <= rd_data_q;
				end
				default: begin
					status_q  <= STS_OK;
					found_q   <= 1'b0;
					key_out_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.do_clear) begin
			count_q <= '0;
		end else if (cmd.do_insert) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	assign status    = status_q;
	assign found     = found_q;
	assign key_out   = key_out_q;
	assign count_now = count_q;

endmodule

/* rtl/akt_ctrl.sv */
module akt_ctrl import akt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  akt_stat_t stat,
	output akt_cmd_t  cmd,
	output logic      busy,
	output logic      done
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_RDWAIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;
	logic   done_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (stat.req)
					REQ_INSERT: begin
						cmd.finish = 1'b1;
						if (stat.full) begin
							cmd.res_sel = RES_FULL;
						end else begin
							cmd.do_insert = 1'b1;
							cmd.res_sel   = RES_OK;
						end
						state_d = ST_IDLE;
					end
					REQ_LOOKUP: begin
						if (stat.empty) begin
							cmd.finish  = 1'b1;
							cmd.res_sel = RES_OK;
							state_d     = ST_IDLE;
						end else begin
							cmd.scan_first = 1'b1;
							state_d        = ST_SCAN;
						end
					end
					REQ_READ: begin
						if (stat.bad_entry) begin
							cmd.finish  = 1'b1;
							cmd.res_sel = RES_BAD;
							state_d     = ST_IDLE;
						end else begin
							cmd.read_issue = 1'b1;
							state_d        = ST_RDWAIT;
						end
					end
					default: begin
						cmd.do_clear = 1'b1;
						cmd.finish   = 1'b1;
						cmd.res_sel  = RES_OK;
						state_d      = ST_IDLE;
					end
				endcase
			end
			ST_SCAN: begin
				// compare the word fetched last cycle, fetch the next one on a miss that is not the last entry
				if (stat.match) begin
					cmd.finish  = 1'b1;
					cmd.res_sel = RES_HIT;
					state_d     = ST_IDLE;
				end else if (stat.last) begin
					cmd.finish  = 1'b1;
					cmd.res_sel = RES_OK;
					state_d     = ST_IDLE;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			ST_RDWAIT: begin
				cmd.finish  = 1'b1;
				cmd.res_sel = RES_KEY;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE);
			done_q  <= cmd.finish;
		end
	end

	assign busy = busy_q;
	assign done = done_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy_q) |=> busy_q)
		else $error("busy not raised after accepted word");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("result strobe while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");

	a_scan_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (stat.req == REQ_LOOKUP))
		else $error("scan running for a non-lookup request");

endmodule

/* sim/tb_access_key_table.sv */
module tb_access_key_table;
	import akt_pkg::*;

	localparam int TABLE_DEPTH  = 64;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 80;
	localparam int MIX_BLOCKS   = 8;
	localparam int MIX_BLOCK_LEN = 200;

	typedef struct {
		logic [STS_W-1:0] status;
		logic             found;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] count;
	} table_reply_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [REQ_W-1:0] req_type;
	logic [KEY_W-1:0] key_value;
	logic [CNT_W-1:0] entry_number;
	logic             done;
	logic [STS_W-1:0] status;
	logic             found;
	logic [KEY_W-1:0] key_out;
	logic [CNT_W-1:0] count_now;

	access_key_table #(.MAX_KEYS(TABLE_DEPTH)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.key_value    (key_value),
		.entry_number (entry_number),
		.done         (done),
		.status       (status),
		.found        (found),
		.key_out      (key_out),
		.count_now    (count_now)
	);

	logic [KEY_W-1:0] shadow_keys [TABLE_DEPTH];
	int               shadow_count;
	table_reply_t     expected_replies [$];
	table_reply_t     oldest_reply;
	int               errors;
	int               n_words;
	int               n_replies;
	int               n_hits;
	int               n_full;
	int               n_bad_reads;
	int               n_clears;
	int               idle_cycles;
	bit               idle_on;

	always #5 clk = ~clk;

	function automatic logic [KEY_W-1:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	// Shadow the table and work out the reply to one request word.
	function automatic table_reply_t predict_table_reply(req_t req, logic [KEY_W-1:0] key,
			logic [CNT_W-1:0] entry);
		table_reply_t r;
		r.status = STS_OK;
		r.found  = 1'b0;
		r.key    = '0;
		case (req)
			REQ_INSERT: begin
				if (shadow_count >= TABLE_DEPTH) begin
					r.status = STS_FULL;
				end else begin
					shadow_keys[shadow_count] = key;
					shadow_count++;
				end
			end
			REQ_LOOKUP: begin
				for (int i = 0; i < shadow_count; i++)
					if (shadow_keys[i] === key)
						r.found = 1'b1;
			end
			REQ_READ: begin
				if (entry == 0 || int'(entry) > shadow_count)
					r.status = STS_BAD_ENTRY;
				else
					r.key = shadow_keys[int'(entry) - 1];
			end
			default: begin
				shadow_count = 0;
			end
		endcase
		r.count = shadow_count[CNT_W-1:0];
		return r;
	endfunction

	task automatic issue_request(req_t req, logic [KEY_W-1:0] key, logic [CNT_W-1:0] entry);
		table_reply_t r;
		int           gap;
		if (idle_on && $urandom_range(99) < 29) begin
			gap = ($urandom_range(3) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 3);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		req_type     <= req;
		key_value    <= key;
		entry_number <= entry;
		do @(posedge clk); while (busy);
		r = predict_table_reply(req, key, entry);
		expected_replies.push_back(r);
		n_words++;
		if (r.found)
			n_hits++;
		if (r.status == STS_FULL)
			n_full++;
		if (r.status == STS_BAD_ENTRY)
			n_bad_reads++;
		if (req == REQ_CLEAR)
			n_clears++;
	endtask

	task automatic insert_key(logic [KEY_W-1:0] key);
		issue_request(REQ_INSERT, key, CNT_W'($urandom));
	endtask

	task automatic lookup_key(logic [KEY_W-1:0] key);
		issue_request(REQ_LOOKUP, key, CNT_W'($urandom));
	endtask

	task automatic read_entry(int entry);
		issue_request(REQ_READ, rand_key(), CNT_W'(entry));
	endtask

	task automatic clear_table();
		issue_request(REQ_CLEAR, rand_key(), CNT_W'($urandom));
	endtask

	task automatic test_directed_cases();
		logic [KEY_W-1:0] key_a;
		logic [KEY_W-1:0] key_b;
		logic [KEY_W-1:0] key_c;
		key_a = 64'h1111_1111_2222_2222;
		key_b = 64'h3333_3333_4444_4444;
		key_c = 64'h8C5A_0000_0012_F001;
		lookup_key('0);
		read_entry(0);
		read_entry(1);
		insert_key('0);
		insert_key('1);
		insert_key(key_a);
		insert_key(key_b);
		lookup_key('0);
		lookup_key('1);
		// low half of one entry, high half of the next: must miss
		lookup_key({key_b[63:32], key_a[31:0]});
		lookup_key(key_b);
		read_entry(1);
		read_entry(2);
		read_entry(4);
		read_entry(5);
		read_entry(127);
		read_entry(0);
		clear_table();
		// stale words stay in memory after a clear but must not be seen
		lookup_key('1);
		read_entry(1);
		insert_key(key_c);
		read_entry(1);
		lookup_key(key_b);
		clear_table();
		clear_table();
	endtask

	task automatic test_fill_to_capacity();
		logic [KEY_W-1:0] first_key;
		logic [KEY_W-1:0] last_key;
		clear_table();
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (i > 0 && $urandom_range(9) == 0)
				last_key = shadow_keys[$urandom_range(i - 1)];
			else
				last_key = rand_key();
			if (i == 0)
				first_key = last_key;
			insert_key(last_key);
		end
		repeat (3) insert_key(rand_key());
		lookup_key(last_key);
		lookup_key(first_key);
		lookup_key(last_key ^ 64'h8000_0000_0000_0000);
		lookup_key(rand_key());
		read_entry(TABLE_DEPTH);
		read_entry(TABLE_DEPTH + 1);
		read_entry(1);
		read_entry(127);
		clear_table();
	endtask

	task automatic test_random_mix();
		int               clear_pct;
		int               roll;
		logic [KEY_W-1:0] key;
		for (int blk = 0; blk < MIX_BLOCKS; blk++) begin
			// hold the request line steady for two whole blocks
			idle_on   = !(blk == 3 || blk == 4);
			// a zero clear rate lets the table run up to full
			clear_pct = $urandom_range(0, 6);
			for (int n = 0; n < MIX_BLOCK_LEN; n++) begin
				roll = $urandom_range(99);
				if (roll < clear_pct) begin
					clear_table();
				end else begin
					roll = $urandom_range(99);
					if (roll < 35) begin
						if (shadow_count > 0 && $urandom_range(4) == 0)
							key = shadow_keys[$urandom_range(shadow_count - 1)];
						else
							key = rand_key();
						insert_key(key);
					end else if (roll < 70) begin
						roll = $urandom_range(99);
						if (shadow_count == 0 || roll >= 70)
							key = rand_key();
						else if (roll < 50)
							key = shadow_keys[$urandom_range(shadow_count - 1)];
						else
							key = shadow_keys[$urandom_range(shadow_count - 1)] ^
								(64'd1 << $urandom_range(KEY_W - 1));
						lookup_key(key);
					end else begin
						roll = $urandom_range(99);
						if (shadow_count > 0 && roll < 70)
							read_entry($urandom_range(1, shadow_count));
						else if (roll < 80)
							read_entry(0);
						else if (roll < 90)
							read_entry(shadow_count + 1);
						else
							read_entry($urandom_range(127));
					end
				end
			end
		end
		idle_on = 1'b1;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_replies.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display({"%0t: result word with nothing pending: ",
						"status=%0d found=%0d key=%h count=%0d"},
						$realtime, status, found, key_out, count_now);
			end else begin
				oldest_reply = expected_replies.pop_front();
				n_replies++;
				if (status !== oldest_reply.status || found !== oldest_reply.found ||
						key_out !== oldest_reply.key || count_now !== oldest_reply.count) begin
					errors++;
					if (errors <= 10)
						$display({"%0t: mismatch: ",
							"exp status=%0d found=%0d key=%h count=%0d, ",
							"got status=%0d found=%0d key=%h count=%0d"},
							$realtime, oldest_reply.status, oldest_reply.found,
							oldest_reply.key, oldest_reply.count,
							status, found, key_out, count_now);
				end
			end
		end
	end

	// Stop the run when no word moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		req_type     = '0;
		key_value    = '0;
		entry_number = '0;
		shadow_count = 0;
		errors       = 0;
		n_words      = 0;
		n_replies    = 0;
		n_hits       = 0;
		n_full       = 0;
		n_bad_reads  = 0;
		n_clears     = 0;
		idle_on      = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_fill_to_capacity();
		test_random_mix();

		start <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d request words, checked %0d result words, %0d mismatches.",
			n_words, n_replies, errors);
		$display({"Covered %0d lookup hits, %0d inserts on a full table, ",
			"%0d bad entry reads, %0d clears."},
			n_hits, n_full, n_bad_reads, n_clears);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
